// ===== rtl/rcg_pkg.sv =====
// Shared widths, codes, item types and reset values for the resource count governor.
package rcg_pkg;

    localparam int COUNT_BITS     = 16;
    localparam int CFG_FIELD_BITS = 16;
    localparam int VAL_BITS       = (COUNT_BITS > CFG_FIELD_BITS) ? COUNT_BITS : CFG_FIELD_BITS;
    localparam int ERR_BITS       = 16;
    localparam int TOTAL_BITS     = 32;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 3;

    // Opcodes of an input item
    localparam logic [1:0] OP_REPORT = 2'd0;
    localparam logic [1:0] OP_ADJUST = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_NONE         = 3'd0;
    localparam logic [2:0] ST_SUCCESS      = 3'd1;
    localparam logic [2:0] ST_NO_CHANGE    = 3'd2;
    localparam logic [2:0] ST_ERROR        = 3'd3;
    localparam logic [2:0] ST_INSUFFICIENT = 3'd4;

    // Strategy codes; unlisted codes behave as balanced
    localparam logic [2:0] STRAT_CONSERVATIVE = 3'd0;
    localparam logic [2:0] STRAT_BALANCED     = 3'd1;
    localparam logic [2:0] STRAT_AGGRESSIVE   = 3'd2;
    localparam logic [2:0] STRAT_ADAPTIVE     = 3'd3;

    // Mode codes
    localparam logic [1:0] MODE_MANUAL     = 2'd0;
    localparam logic [1:0] MODE_ON_DEMAND  = 2'd1;
    localparam logic [1:0] MODE_PERIODIC   = 2'd2;
    localparam logic [1:0] MODE_CONTINUOUS = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_COUNT       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_COUNT       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OPTIMAL_COUNT   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ERR_LIMIT       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STRATEGY_SELECT = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE_SELECT     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INTERVAL_MS     = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AUTO_ENABLE     = 3'd7;

    // Register reset values
    localparam logic [CFG_FIELD_BITS-1:0] RST_MIN_COUNT       = 16'd5;
    localparam logic [CFG_FIELD_BITS-1:0] RST_MAX_COUNT       = 16'd0;
    localparam logic [CFG_FIELD_BITS-1:0] RST_OPTIMAL_COUNT   = 16'd0;
    localparam logic [ERR_BITS-1:0]       RST_ERR_LIMIT       = 16'd3277;
    localparam logic [2:0]                RST_STRATEGY_SELECT = STRAT_BALANCED;
    localparam logic [1:0]                RST_MODE_SELECT     = MODE_ON_DEMAND;
    localparam logic [TOTAL_BITS-1:0]     RST_INTERVAL_MS     = 32'd60000;
    localparam logic                      RST_AUTO_ENABLE     = 1'b0;

    typedef struct packed {
        logic [1:0]            opcode;
        logic [COUNT_BITS-1:0] active_count;
        logic [ERR_BITS-1:0]   err_sample;
        logic [COUNT_BITS-1:0] device_max;
        logic                  device_valid;
    } req_t;

    typedef struct packed {
        logic [2:0]            status;
        logic [COUNT_BITS-1:0] current_count;
        logic [COUNT_BITS-1:0] recommended_count;
        logic [COUNT_BITS-1:0] peak_count;
        logic [TOTAL_BITS-1:0] adjust_total;
        logic [TOTAL_BITS-1:0] fail_total;
        logic [ERR_BITS-1:0]   avg_error;
    } rsp_t;

    typedef struct packed {
        logic [CFG_FIELD_BITS-1:0] min_count;
        logic [CFG_FIELD_BITS-1:0] max_count;
        logic [CFG_FIELD_BITS-1:0] optimal_count;
        logic [ERR_BITS-1:0]       err_limit;
        logic [2:0]                strategy_select;
        logic [1:0]                mode_select;
        logic [TOTAL_BITS-1:0]     interval_ms;
        logic                      auto_enable;
    } cfg_t;

endpackage

// ===== rtl/resource_count_governor.sv =====
// Top level of the resource count governor: item holding stage, state, result register.
// An accepted item waits in the holding stage until the result register can take its result.
// Throughput: one item per cycle while not stalled; state and result load share one edge.
// An empty holding stage takes a new item while a finished result still waits on rsp_ready.
// Reset: asynchronous, active low; clears both stages, the state and the registers to defaults.
// Configuration writes take effect on the next cycle and are expected only while idle.
module resource_count_governor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  rcg_pkg::req_t                         req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output rcg_pkg::rsp_t                         rsp,
    input  logic                                  cfg_we,
    input  logic [rcg_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [rcg_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import rcg_pkg::*;

    localparam int          SUM_BITS     = ERR_BITS + 4;
    localparam int          SMOOTH_SHIFT = SUM_BITS + 4;
    localparam int          RECIP_BITS   = SUM_BITS + 1;
    localparam logic [63:0] SMOOTH_R64   = ((64'd1 << SMOOTH_SHIFT) + 64'd9) / 64'd10;
    localparam logic [RECIP_BITS-1:0] SMOOTH_RECIP = SMOOTH_R64[RECIP_BITS-1:0];
    localparam int          TW           = COUNT_BITS + 4;

    cfg_t cfg;

    logic                   hold_valid_reg;
    req_t                   hold_reg;
    logic                   rsp_valid_reg;
    rsp_t                   rsp_reg;
    rsp_t                   rsp_next;
    logic                   advance;

    logic [COUNT_BITS-1:0]  cur_reg, cur_next;
    logic [COUNT_BITS-1:0]  last_reg, last_next;
    logic [ERR_BITS-1:0]    avg_reg, avg_next;
    logic [TOTAL_BITS-1:0]  elapsed_reg, elapsed_next;
    logic [COUNT_BITS-1:0]  peak_reg, peak_next;
    logic [TOTAL_BITS-1:0]  success_reg, success_next;
    logic [TOTAL_BITS-1:0]  failure_reg, failure_next;

    logic [SUM_BITS-1:0]    smooth_sum;
    logic [SUM_BITS+RECIP_BITS-1:0] smooth_prod;
    logic [ERR_BITS-1:0]    smooth_q;
    logic [COUNT_BITS-1:0]  rec_last;
    logic [ERR_BITS-1:0]    rec_avg;
    logic [COUNT_BITS-1:0]  rec;
    logic [COUNT_BITS-1:0]  rec_out;
    logic [2:0]             status_next;
    logic                   go;
    logic                   do_adjust;
    logic                   short_device;
    logic [TW-1:0]          act10, cur9;

    rcg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the holding stage drains whenever the result register can take a result
    assign advance   = hold_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !hold_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Smoothed error: floor((7*avg + 3*err) / 10) through a scaled reciprocal
    assign smooth_sum  = SUM_BITS'(avg_reg) * SUM_BITS'(7)
                       + SUM_BITS'(hold_reg.err_sample) * SUM_BITS'(3);
    assign smooth_prod = {{RECIP_BITS{1'b0}}, smooth_sum} * {{SUM_BITS{1'b0}}, SMOOTH_RECIP};
    assign smooth_q    = smooth_prod[SMOOTH_SHIFT +: ERR_BITS];

    // A report updates last active and the average before any adjustment sees them
    assign rec_last = (hold_reg.opcode == OP_REPORT) ? hold_reg.active_count : last_reg;
    assign rec_avg  = (hold_reg.opcode == OP_REPORT)
                    ? ((avg_reg == '0) ? hold_reg.err_sample : smooth_q)
                    : avg_reg;

    rcg_recommend u_recommend (
        .cfg          (cfg),
        .device_max   (hold_reg.device_max),
        .device_valid (hold_reg.device_valid),
        .cur          (cur_reg),
        .last         (rec_last),
        .avg          (rec_avg),
        .rec          (rec)
    );

    // Auto trigger on a usage report
    assign act10 = TW'(hold_reg.active_count) * TW'(10);
    assign cur9  = TW'(cur_reg) * TW'(9);

    always_comb
    begin
        go = 1'b0;
        if (cfg.auto_enable)
        begin
            unique case (cfg.mode_select)
                MODE_MANUAL:     go = 1'b0;
                MODE_ON_DEMAND:  go = (act10 > cur9)
                                   || (hold_reg.err_sample > cfg.err_limit);
                MODE_PERIODIC:   go = elapsed_reg >= cfg.interval_ms;
                MODE_CONTINUOUS: go = 1'b1;
                default:         go = 1'b0;
            endcase
        end
    end

    assign short_device = VAL_BITS'(hold_reg.device_max) < VAL_BITS'(cfg.min_count);

    // Item execution: state update and result
    always_comb
    begin
        cur_next     = cur_reg;
        last_next    = last_reg;
        avg_next     = avg_reg;
        elapsed_next = elapsed_reg;
        peak_next    = peak_reg;
        success_next = success_reg;
        failure_next = failure_reg;
        status_next  = ST_NONE;
        rec_out      = '0;
        do_adjust    = 1'b0;

        unique case (hold_reg.opcode)
            OP_REPORT:
            begin
                last_next = rec_last;
                avg_next  = rec_avg;
                do_adjust = go;
            end
            OP_ADJUST:
            begin
                do_adjust = 1'b1;
            end
            OP_TICK:
            begin
                if (elapsed_reg != '1)
                    elapsed_next = elapsed_reg + 1'b1;
            end
            OP_QUERY:
            begin
                rec_out = rec;
            end
            default:
            begin
                do_adjust = 1'b0;
            end
        endcase

        // Apply the recommendation
        if (do_adjust)
        begin
            rec_out = rec;
            priority if (rec == '0)
            begin
                failure_next = failure_reg + 1'b1;
                status_next  = ST_ERROR;
            end
            else if ((cur_reg != '0) && (rec == cur_reg))
            begin
                status_next = ST_NO_CHANGE;
            end
            else if (!hold_reg.device_valid)
            begin
                failure_next = failure_reg + 1'b1;
                status_next  = ST_ERROR;
            end
            else if ((rec > hold_reg.device_max) && short_device)
            begin
                failure_next = failure_reg + 1'b1;
                status_next  = ST_INSUFFICIENT;
            end
            else
            begin
                cur_next     = (rec > hold_reg.device_max) ? hold_reg.device_max : rec;
                peak_next    = (cur_next > peak_reg) ? cur_next : peak_reg;
                success_next = success_reg + 1'b1;
                elapsed_next = '0;
                status_next  = ST_SUCCESS;
            end
        end

        rsp_next.status            = status_next;
        rsp_next.current_count     = cur_next;
        rsp_next.recommended_count = rec_out;
        rsp_next.peak_count        = peak_next;
        rsp_next.adjust_total      = success_next;
        rsp_next.fail_total        = failure_next;
        rsp_next.avg_error         = avg_next;
    end

    // Holding stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else if (req_ready)
            hold_valid_reg <= req_valid;
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
            hold_reg <= req;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (advance)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            rsp_reg <= rsp_next;
    end

    // Governor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            last_reg    <= '0;
            avg_reg     <= '0;
            elapsed_reg <= '1;
            peak_reg    <= '0;
            success_reg <= '0;
            failure_reg <= '0;
        end
        else if (advance)
        begin
            cur_reg     <= cur_next;
            last_reg    <= last_next;
            avg_reg     <= avg_next;
            elapsed_reg <= elapsed_next;
            peak_reg    <= peak_next;
            success_reg <= success_next;
            failure_reg <= failure_next;
        end
    end

    // Peak never falls below the allocation reported with it
    a_peak_covers_current: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.peak_count >= rsp_reg.current_count))
        else $error("peak count below current count");

    // Success total moves only on a successful adjustment
    a_success_tracks_status: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (success_reg == $past(success_reg)
                     + TOTAL_BITS'($past(status_next) == ST_SUCCESS)))
        else $error("success total out of step with status");

    // A successful adjustment restarts the interval timer
    a_success_clears_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (status_next == ST_SUCCESS)) |=> (elapsed_reg == '0))
        else $error("elapsed time not cleared on adjustment");

    // A held item is not lost or overwritten while the result side stalls
    a_hold_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_valid_reg && !advance) |=> (hold_valid_reg && $stable(hold_reg)))
        else $error("held item dropped while stalled");

endmodule

// ===== rtl/rcg_cfg.sv =====
// Configuration register file of the resource count governor.
module rcg_cfg (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [rcg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [rcg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    output rcg_pkg::cfg_t                          cfg
);
    import rcg_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register, truncated to its width
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_count       <= RST_MIN_COUNT;
            cfg_reg.max_count       <= RST_MAX_COUNT;
            cfg_reg.optimal_count   <= RST_OPTIMAL_COUNT;
            cfg_reg.err_limit       <= RST_ERR_LIMIT;
            cfg_reg.strategy_select <= RST_STRATEGY_SELECT;
            cfg_reg.mode_select     <= RST_MODE_SELECT;
            cfg_reg.interval_ms     <= RST_INTERVAL_MS;
            cfg_reg.auto_enable     <= RST_AUTO_ENABLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_COUNT:       cfg_reg.min_count       <= cfg_data[CFG_FIELD_BITS-1:0];
                REG_MAX_COUNT:       cfg_reg.max_count       <= cfg_data[CFG_FIELD_BITS-1:0];
                REG_OPTIMAL_COUNT:   cfg_reg.optimal_count   <= cfg_data[CFG_FIELD_BITS-1:0];
                REG_ERR_LIMIT:       cfg_reg.err_limit       <= cfg_data[ERR_BITS-1:0];
                REG_STRATEGY_SELECT: cfg_reg.strategy_select <= cfg_data[2:0];
                REG_MODE_SELECT:     cfg_reg.mode_select     <= cfg_data[1:0];
                REG_INTERVAL_MS:     cfg_reg.interval_ms     <= cfg_data[TOTAL_BITS-1:0];
                REG_AUTO_ENABLE:     cfg_reg.auto_enable     <= cfg_data[0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/rcg_pct.sv =====
// Exact floor(x * PERCENT / 100) by one multiplication with a scaled reciprocal.
module rcg_pct #(
    parameter int IN_BITS = 16,
    parameter int PERCENT = 85
) (
    input  logic [IN_BITS-1:0] x,
    output logic [IN_BITS:0]   q
);
    // x*PERCENT stays below 2^(IN_BITS+7); seven more bits of shift make the
    // rounded-up reciprocal of 100 exact over that whole range
    localparam int          SHIFT   = IN_BITS + 14;
    localparam int          PM_BITS = IN_BITS + 15;
    localparam logic [63:0] RECIP   = ((64'd1 << SHIFT) + 64'd99) / 64'd100;
    localparam logic [63:0] SCALE64 = RECIP * 64'(PERCENT);
    localparam logic [PM_BITS-1:0] SCALE = SCALE64[PM_BITS-1:0];

    logic [IN_BITS+PM_BITS-1:0] prod;

    // Multiply once, keep the integer part
    assign prod = {{PM_BITS{1'b0}}, x} * {{IN_BITS{1'b0}}, SCALE};
    assign q    = prod[SHIFT +: IN_BITS+1];

endmodule

// ===== rtl/rcg_recommend.sv =====
// Recommendation datapath: strategy selection, adaptive rules and final clamping.
module rcg_recommend (
    input  rcg_pkg::cfg_t                       cfg,
    input  logic [rcg_pkg::COUNT_BITS-1:0]      device_max,
    input  logic                                device_valid,
    input  logic [rcg_pkg::COUNT_BITS-1:0]      cur,
    input  logic [rcg_pkg::COUNT_BITS-1:0]      last,
    input  logic [rcg_pkg::ERR_BITS-1:0]        avg,
    output logic [rcg_pkg::COUNT_BITS-1:0]      rec
);
    import rcg_pkg::*;

    localparam int RW = VAL_BITS + 1;
    localparam int BW = COUNT_BITS + 7;
    localparam int EW = ERR_BITS + 4;

    logic [COUNT_BITS:0] p70_d, p85_d, p95_d, p115_c, p85_c, p90_c;
    logic [RW-1:0] dmax_w, min_w, max_w, opt_w, cur_w;
    logic [RW-1:0] bal_r, adapt_r, pick_r, lo_r, hi_r;
    logic [BW-1:0] last100, cur85;
    logic [EW-1:0] avg10, tol8, tol12;
    logic          below_min, err_low, err_high, busy, sparse;

    // Percentage shares of the device limit and of the current allocation
    rcg_pct #(.IN_BITS(COUNT_BITS), .PERCENT(70))  u_p70_d  (.x(device_max), .q(p70_d));
    rcg_pct #(.IN_BITS(COUNT_BITS), .PERCENT(85))  u_p85_d  (.x(device_max), .q(p85_d));
    rcg_pct #(.IN_BITS(COUNT_BITS), .PERCENT(95))  u_p95_d  (.x(device_max), .q(p95_d));
    rcg_pct #(.IN_BITS(COUNT_BITS), .PERCENT(115)) u_p115_c (.x(cur),        .q(p115_c));
    rcg_pct #(.IN_BITS(COUNT_BITS), .PERCENT(85))  u_p85_c  (.x(cur),        .q(p85_c));
    rcg_pct #(.IN_BITS(COUNT_BITS), .PERCENT(90))  u_p90_c  (.x(cur),        .q(p90_c));

    // Widen everything to one compare width
    assign dmax_w    = RW'(device_max);
    assign min_w     = RW'(cfg.min_count);
    assign max_w     = RW'(cfg.max_count);
    assign opt_w     = RW'(cfg.optimal_count);
    assign cur_w     = RW'(cur);
    assign below_min = dmax_w < min_w;

    // Ratio tests as cross-multiplications
    assign avg10    = EW'(avg) * EW'(10);
    assign tol8     = EW'(cfg.err_limit) << 3;
    assign tol12    = EW'(cfg.err_limit) * EW'(12);
    assign err_low  = avg10 < tol8;
    assign err_high = avg10 > tol12;
    assign last100  = BW'(last) * BW'(100);
    assign cur85    = BW'(cur) * BW'(85);
    assign busy     = last100 > cur85;
    assign sparse   = ((COUNT_BITS+1)'(last) << 1) < (COUNT_BITS+1)'(cur);

    // Balanced above the minimum: optimal count when set, else 85 percent of the device
    always_comb
    begin
        priority if (below_min)
            bal_r = dmax_w;
        else if (opt_w != '0)
            bal_r = (opt_w <= dmax_w) ? opt_w : dmax_w;
        else
            bal_r = (RW'(p85_d) > min_w) ? RW'(p85_d) : min_w;
    end

    // Adaptive: grow when busy and clean, shrink when sparse or noisy
    always_comb
    begin
        priority if (below_min)
            adapt_r = dmax_w;
        else if (cur_w == '0)
            adapt_r = bal_r;
        else if (busy && err_low)
            adapt_r = (RW'(p115_c) <= dmax_w) ? RW'(p115_c) : dmax_w;
        else if (sparse)
            adapt_r = (RW'(p85_c) > min_w) ? RW'(p85_c) : min_w;
        else if (err_high)
            adapt_r = (RW'(p90_c) > min_w) ? RW'(p90_c) : min_w;
        else
            adapt_r = cur_w;
    end

    // Pick the strategy
    always_comb
    begin
        priority if (cfg.strategy_select == STRAT_ADAPTIVE)
            pick_r = adapt_r;
        else if (below_min)
            pick_r = dmax_w;
        else if (cfg.strategy_select == STRAT_CONSERVATIVE)
            pick_r = (RW'(p70_d) > min_w) ? RW'(p70_d) : min_w;
        else if (cfg.strategy_select == STRAT_AGGRESSIVE)
            pick_r = (RW'(p95_d) > min_w) ? RW'(p95_d) : min_w;
        else
            pick_r = bal_r;
    end

    // Clamp to the minimum, then to a nonzero maximum; invalid device gives zero
    assign lo_r = (pick_r < min_w) ? min_w : pick_r;
    assign hi_r = ((max_w != '0) && (lo_r > max_w)) ? max_w : lo_r;
    assign rec  = device_valid ? hi_r[COUNT_BITS-1:0] : '0;

endmodule

// ===== tb/sv/rcg_checker.sv =====
// Scoreboard for the resource count governor: predicts every result and compares it.
`timescale 1ns / 1ps
module rcg_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    input  logic                               req_ready,
    input  rcg_pkg::req_t                      req,
    input  logic                               rsp_valid,
    input  logic                               rsp_ready,
    input  rcg_pkg::rsp_t                      rsp,
    input  logic                               cfg_we,
    input  logic [rcg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [rcg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int unsigned                        faults,
    output int unsigned                        outstanding,
    output int unsigned                        checked,
    output int unsigned                        granted,
    output int unsigned                        unchanged,
    output int unsigned                        refused
);
    import rcg_pkg::*;

    // Shadow copy of the registers and the governor state
    cfg_t                  cfg;
    logic [COUNT_BITS-1:0] alloc;
    logic [COUNT_BITS-1:0] last_act;
    logic [ERR_BITS-1:0]   avg_err;
    logic [COUNT_BITS-1:0] peak;
    logic [TOTAL_BITS-1:0] ms_since;
    logic [TOTAL_BITS-1:0] wins;
    logic [TOTAL_BITS-1:0] losses;

    rsp_t due_q[$];
    rsp_t want;

    // Exact floor of x * p / 100
    function automatic bit [63:0] share(input bit [63:0] x, input bit [63:0] p);
        return (x * p) / 100;
    endfunction

    function automatic bit [63:0] floor_at_min(input bit [63:0] v);
        return (v > cfg.min_count) ? v : 64'(cfg.min_count);
    endfunction

    function automatic bit [63:0] balanced_pick(input bit [63:0] dmax);
        if (dmax < cfg.min_count)
            return dmax;
        if (cfg.optimal_count != 0)
            return (cfg.optimal_count <= dmax) ? 64'(cfg.optimal_count) : dmax;
        return floor_at_min(share(dmax, 85));
    endfunction

    // Grow when busy and clean, shrink when idle, trim when noisy
    function automatic bit [63:0] adaptive_pick(input bit [63:0] dmax);
        bit [63:0] cur;
        bit [63:0] act;
        bit [63:0] err;
        bit [63:0] tol;
        bit [63:0] grown;
        bit        err_low;
        bit        err_high;
        cur = alloc;
        act = last_act;
        err = avg_err;
        tol = cfg.err_limit;
        if (dmax < cfg.min_count)
            return dmax;
        if (cur == 0)
            return balanced_pick(dmax);
        err_low  = err * 10 < tol * 8;
        err_high = err * 10 > tol * 12;
        if (act * 100 > cur * 85 && err_low)
        begin
            grown = share(cur, 115);
            return (grown <= dmax) ? grown : dmax;
        end
        if (act * 2 < cur)
            return floor_at_min(share(cur, 85));
        if (err_high)
            return floor_at_min(share(cur, 90));
        return cur;
    endfunction

    // Clamped recommendation; zero for a bad device reading
    function automatic logic [COUNT_BITS-1:0] suggest(input logic [COUNT_BITS-1:0] dmax,
                                                      input logic ok);
        bit [63:0] r;
        if (!ok)
            return '0;
        if (cfg.strategy_select == STRAT_ADAPTIVE)
            r = adaptive_pick(dmax);
        else if (dmax < cfg.min_count)
            r = dmax;
        else if (cfg.strategy_select == STRAT_CONSERVATIVE)
            r = floor_at_min(share(dmax, 70));
        else if (cfg.strategy_select == STRAT_AGGRESSIVE)
            r = floor_at_min(share(dmax, 95));
        else
            r = balanced_pick(dmax);
        if (r < cfg.min_count)
            r = cfg.min_count;
        if (cfg.max_count != 0 && r > cfg.max_count)
            r = cfg.max_count;
        return r[COUNT_BITS-1:0];
    endfunction

    // Try to apply a recommendation to the allocation
    function automatic logic [2:0] settle(input logic [COUNT_BITS-1:0] dmax, input logic ok,
                                          output logic [COUNT_BITS-1:0] rec);
        logic [COUNT_BITS-1:0] r;
        r = suggest(dmax, ok);
        rec = r;
        if (r == 0)
        begin
            losses++;
            return ST_ERROR;
        end
        if (alloc != 0 && r == alloc)
            return ST_NO_CHANGE;
        // Cut to the device limit; refuse if that drops below the minimum
        if (r > dmax)
        begin
            r = dmax;
            if (r < cfg.min_count)
            begin
                losses++;
                return ST_INSUFFICIENT;
            end
        end
        alloc = r;
        wins++;
        if (r > peak)
            peak = r;
        ms_since = '0;
        return ST_SUCCESS;
    endfunction

    // Advance the shadow state by one item and form its result
    function automatic rsp_t govern(input req_t it);
        rsp_t                  o;
        logic [2:0]            st;
        logic [COUNT_BITS-1:0] rec;
        bit                    fire;
        bit [63:0]             old_avg;
        bit [63:0]             fresh;
        bit [63:0]             act;
        bit [63:0]             cur;
        st = ST_NONE;
        rec = '0;
        case (it.opcode)
            OP_REPORT:
            begin
                last_act = it.active_count;
                old_avg = avg_err;
                fresh = it.err_sample;
                act = it.active_count;
                cur = alloc;
                if (old_avg == 0)
                    avg_err = it.err_sample;
                else
                    avg_err = ERR_BITS'((7 * old_avg + 3 * fresh) / 10);
                fire = 1'b0;
                if (cfg.auto_enable)
                begin
                    case (cfg.mode_select)
                        MODE_ON_DEMAND:  fire = (act * 10 > cur * 9) ||
                                                (it.err_sample > cfg.err_limit);
                        MODE_PERIODIC:   fire = ms_since >= cfg.interval_ms;
                        MODE_CONTINUOUS: fire = 1'b1;
                        default:         fire = 1'b0;
                    endcase
                end
                if (fire)
                    st = settle(it.device_max, it.device_valid, rec);
            end
            OP_ADJUST:
                st = settle(it.device_max, it.device_valid, rec);
            OP_TICK:
            begin
                if (ms_since != '1)
                    ms_since++;
            end
            default:
                rec = suggest(it.device_max, it.device_valid);
        endcase
        o.status            = st;
        o.current_count     = alloc;
        o.recommended_count = rec;
        o.peak_count        = peak;
        o.adjust_total      = wins;
        o.fail_total        = losses;
        o.avg_error         = avg_err;
        return o;
    endfunction

    function automatic void field_check(input string tag, input logic [31:0] exp_v,
                                        input logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            faults++;
            if (faults <= 10)
                $display("rcg_checker: result %0d %s expected %0d got %0d",
                         checked, tag, exp_v, got_v);
        end
    endfunction

    // Watch the configuration port and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg.min_count       = RST_MIN_COUNT;
            cfg.max_count       = RST_MAX_COUNT;
            cfg.optimal_count   = RST_OPTIMAL_COUNT;
            cfg.err_limit       = RST_ERR_LIMIT;
            cfg.strategy_select = RST_STRATEGY_SELECT;
            cfg.mode_select     = RST_MODE_SELECT;
            cfg.interval_ms     = RST_INTERVAL_MS;
            cfg.auto_enable     = RST_AUTO_ENABLE;
            alloc    = '0;
            last_act = '0;
            avg_err  = '0;
            peak     = '0;
            ms_since = '1;
            wins     = '0;
            losses   = '0;
            due_q.delete();
            faults    = 0;
            checked   = 0;
            granted   = 0;
            unchanged = 0;
            refused   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MIN_COUNT:       cfg.min_count       = cfg_data[15:0];
                    REG_MAX_COUNT:       cfg.max_count       = cfg_data[15:0];
                    REG_OPTIMAL_COUNT:   cfg.optimal_count   = cfg_data[15:0];
                    REG_ERR_LIMIT:       cfg.err_limit       = cfg_data[15:0];
                    REG_STRATEGY_SELECT: cfg.strategy_select = cfg_data[2:0];
                    REG_MODE_SELECT:     cfg.mode_select     = cfg_data[1:0];
                    REG_INTERVAL_MS:     cfg.interval_ms     = cfg_data[31:0];
                    REG_AUTO_ENABLE:     cfg.auto_enable     = cfg_data[0];
                    default: ;
                endcase
            end
            // Compare before predicting, so a result can never match its own item
            if (rsp_valid && rsp_ready)
            begin
                if (due_q.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("rcg_checker: result arrived with nothing expected");
                end
                else
                begin
                    want = due_q.pop_front();
                    field_check("status", want.status, rsp.status);
                    field_check("current_count", want.current_count, rsp.current_count);
                    field_check("recommended_count", want.recommended_count,
                                rsp.recommended_count);
                    field_check("peak_count", want.peak_count, rsp.peak_count);
                    field_check("adjust_total", want.adjust_total, rsp.adjust_total);
                    field_check("fail_total", want.fail_total, rsp.fail_total);
                    field_check("avg_error", want.avg_error, rsp.avg_error);
                    checked++;
                    case (want.status)
                        ST_SUCCESS:                granted++;
                        ST_NO_CHANGE:              unchanged++;
                        ST_ERROR, ST_INSUFFICIENT: refused++;
                        default: ;
                    endcase
                end
            end
            if (req_valid && req_ready)
                due_q.push_back(govern(req));
            outstanding <= due_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the resource count governor testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
    import rcg_pkg::*;

    localparam int LIMIT     = 200000;
    localparam int LONG_HOLD = 250;
    localparam int HOLD_AT   = 300;
    localparam int SETTLE    = 6;
    localparam int PHASES    = 13;
    localparam int PER_PHASE = 50;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      req_valid = 1'b0;
    logic                      rsp_ready = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    req_t                      req       = '0;
    logic                      req_ready;
    logic                      rsp_valid;
    rsp_t                      rsp;

    logic        calm   = 1'b0;
    int unsigned sent   = 0;
    int unsigned cycles = 0;
    int unsigned phases_run = 0;

    int unsigned faults;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned granted;
    int unsigned unchanged;
    int unsigned refused;

    resource_count_governor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rcg_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .faults      (faults),
        .outstanding (outstanding),
        .checked     (checked),
        .granted     (granted),
        .unchanged   (unchanged),
        .refused     (refused)
    );

    always #5 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Hold the item until the block takes it
    task automatic offer(input req_t item);
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sent <= sent + 1;
    endtask

    // Offer one item, then maybe leave a gap
    task automatic push_item(input req_t item);
        offer(item);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Drop valid and wait for every expected result, then let the block settle
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // Write all eight registers; unused upper bits carry junk
    task automatic set_regs(input logic [15:0] mn, input logic [15:0] mx,
                            input logic [15:0] opt, input logic [15:0] tol,
                            input logic [2:0] strat, input logic [1:0] mode,
                            input logic [31:0] ivl, input logic en);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_MIN_COUNT, {junk[31:16], mn});
        write_reg(REG_MAX_COUNT, {junk[31:16], mx});
        write_reg(REG_OPTIMAL_COUNT, {junk[31:16], opt});
        write_reg(REG_ERR_LIMIT, {junk[31:16], tol});
        write_reg(REG_STRATEGY_SELECT, {junk[31:3], strat});
        write_reg(REG_MODE_SELECT, {junk[31:2], mode});
        write_reg(REG_INTERVAL_MS, ivl);
        write_reg(REG_AUTO_ENABLE, {junk[31:1], en});
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    function automatic req_t mk(input logic [1:0] op, input logic [15:0] act,
                                input logic [15:0] err, input logic [15:0] dmax,
                                input logic ok);
        req_t it;
        it.opcode       = op;
        it.active_count = act;
        it.err_sample   = err;
        it.device_max   = dmax;
        it.device_valid = ok;
        return it;
    endfunction

    // Half the time a value up to the phase's scale, else zero, all ones or any value
    function automatic logic [15:0] pick16(input int unsigned scale);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(0, scale));
        endcase
    endfunction

    function automatic req_t rand_item(input int unsigned scale);
        req_t        it;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            it.opcode = OP_REPORT;
        else if (roll < 60)
            it.opcode = OP_ADJUST;
        else if (roll < 85)
            it.opcode = OP_TICK;
        else
            it.opcode = OP_QUERY;
        it.active_count = pick16(scale);
        it.err_sample   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 8000))
                                                      : pick16(65535);
        it.device_max   = pick16(scale);
        it.device_valid = ($urandom_range(0, 9) != 0);
        return it;
    endfunction

    // Result side: short random stalls, one long hold-off to back up the block
    initial
    begin : receiver
        bit          squeezed;
        int unsigned n;
        squeezed = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (!squeezed && sent >= HOLD_AT)
            begin
                squeezed = 1'b1;
                rsp_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                rsp_ready <= 1'b0;
                n = $urandom_range(1, 17);
                repeat (n - 1) @(posedge clk);
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int unsigned scale;
        logic [15:0] mn;
        logic [15:0] mx;
        logic [15:0] opt;
        logic [15:0] tol;
        logic [31:0] ivl;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Defaults: queries, each adjust outcome, bad device, device below minimum
        push_item(mk(OP_QUERY, 16'd0, 16'd0, 16'd100, 1'b1));
        push_item(mk(OP_QUERY, 16'd0, 16'd0, 16'd100, 1'b0));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'd100, 1'b1));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'd100, 1'b1));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'd100, 1'b0));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'd3, 1'b1));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'hFFFF, 1'b1));
        push_item(mk(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        push_item(mk(OP_REPORT, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1));
        push_item(mk(OP_QUERY, 16'd0, 16'd0, 16'd0, 1'b1));
        drain();

        // Adaptive with zero tolerance, continuous: zero average, then high error
        set_regs(16'd5, 16'd0, 16'd0, 16'd0, STRAT_ADAPTIVE, MODE_CONTINUOUS, 32'd60000, 1'b1);
        push_item(mk(OP_REPORT, 16'd0, 16'd0, 16'hFFFF, 1'b1));
        push_item(mk(OP_REPORT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1));
        push_item(mk(OP_REPORT, 16'd40000, 16'd1, 16'hFFFF, 1'b1));
        push_item(mk(OP_REPORT, 16'd1, 16'd0, 16'hFFFF, 1'b0));
        drain();

        // Full tolerance on demand: growth, then a report that triggers nothing
        set_regs(16'd5, 16'd0, 16'd0, 16'hFFFF, STRAT_ADAPTIVE, MODE_ON_DEMAND,
                 32'd60000, 1'b1);
        push_item(mk(OP_REPORT, 16'hFFFF, 16'd0, 16'hFFFF, 1'b1));
        push_item(mk(OP_REPORT, 16'd0, 16'd0, 16'hFFFF, 1'b1));
        drain();

        // Top extremes, unlisted strategy code, periodic with the longest interval
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd3277, 3'd4, MODE_PERIODIC,
                 32'hFFFF_FFFF, 1'b1);
        push_item(mk(OP_REPORT, 16'd10, 16'd10, 16'hFFFF, 1'b1));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'hFFFF, 1'b1));
        push_item(mk(OP_QUERY, 16'd0, 16'd0, 16'h7FFF, 1'b1));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'h1234, 1'b1));
        drain();

        // Zero minimum and interval: a zero recommendation, then the maximum clamp
        set_regs(16'd0, 16'd16, 16'd0, 16'd0, STRAT_CONSERVATIVE, MODE_PERIODIC, 32'd0, 1'b1);
        push_item(mk(OP_REPORT, 16'd0, 16'd0, 16'd0, 1'b1));
        push_item(mk(OP_TICK, 16'd0, 16'd0, 16'd0, 1'b0));
        push_item(mk(OP_REPORT, 16'd500, 16'd0, 16'd1000, 1'b1));
        drain();

        // Manual mode ignores reports even with auto on
        set_regs(16'd5, 16'd0, 16'd0, 16'd3277, STRAT_AGGRESSIVE, MODE_MANUAL, 32'd1, 1'b1);
        push_item(mk(OP_REPORT, 16'hFFFF, 16'hFFFF, 16'd1000, 1'b1));
        push_item(mk(OP_ADJUST, 16'd0, 16'd0, 16'd1000, 1'b1));
        drain();

        // Random phases, each under a fresh random setting; the last one runs without idling
        for (int ph = 0; ph < PHASES; ph++)
        begin
            scale = (ph % 3 == 0) ? 200 : (ph % 3 == 1) ? 4000 : 65535;
            calm = (ph == PHASES - 1);
            case ($urandom_range(0, 9))
                0:       mn = '0;
                1:       mn = 16'hFFFF;
                2:       mn = 16'($urandom);
                default: mn = 16'($urandom_range(0, scale / 8));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mx = '0;
                4:          mx = 16'hFFFF;
                5:          mx = 16'($urandom);
                default:    mx = 16'($urandom_range(scale / 4, scale));
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: opt = '0;
                5:             opt = 16'hFFFF;
                default:       opt = 16'($urandom_range(0, scale));
            endcase
            case ($urandom_range(0, 9))
                0:       tol = '0;
                1:       tol = 16'hFFFF;
                2:       tol = 16'($urandom);
                default: tol = 16'($urandom_range(0, 8000));
            endcase
            case ($urandom_range(0, 9))
                0:       ivl = '0;
                1:       ivl = 32'hFFFF_FFFF;
                2:       ivl = $urandom;
                default: ivl = $urandom_range(0, 12);
            endcase
            set_regs(mn, mx, opt, tol, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                     ivl, $urandom_range(0, 3) != 0);
            repeat (PER_PHASE) push_item(rand_item(scale));
            drain();
        end

        $display("tb_top: %0d items over %0d register settings, %0d results compared",
                 sent, phases_run, checked);
        $display("tb_top: adjustments granted %0d, unchanged %0d, refused %0d",
                 granted, unchanged, refused);
        if (faults == 0 && outstanding == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
